[rtl/piecewise_linear_loglik_defines.svh]
// assertion helpers shared by the block
`ifndef PIECEWISE_LINEAR_LOGLIK_DEFINES_SVH
`define PIECEWISE_LINEAR_LOGLIK_DEFINES_SVH

// same-cycle implication
`define PLL_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("piecewise_linear_loglik: check failed");

// next-cycle implication
`define PLL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("piecewise_linear_loglik: check failed");

`endif

[rtl/pll_pkg.sv]
package pll_pkg;

   localparam int MAX_SEGMENTS = 8;
   localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DATA_W = 32;
   localparam int TERM_W = 49;
   localparam int SUM_W  = TERM_W + CNT_W + 1;
   localparam int ACC_W  = 48;
   localparam int PEN_W  = 49;

   localparam logic [DATA_W-1:0] ITV_RESET = 32'd32768;

   typedef enum logic [1:0] {
      CSR_SEGMENT_COUNT    = 2'd0,
      CSR_INTERCEPT        = 2'd1,
      CSR_INV_TWO_VARIANCE = 2'd2,
      CSR_LOG_NORM         = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef struct packed {
      logic                   is_write;
      logic [SEG_IDX_W-1:0]   seg;
      logic [DATA_W-1:0]      slope;
      logic [DATA_W-1:0]      bp;
      logic [DATA_W-1:0]      x;
      logic [DATA_W-1:0]      y;
      logic                   last;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] intercept;
      logic [DATA_W-1:0] inv_two_variance;
      logic [DATA_W-1:0] log_norm;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic loading;
   } back_status_type;

endpackage

[rtl/pll_front.sv]
module pll_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [3:0]             req_segment_index,
   input  logic [31:0]            req_segment_slope,
   input  logic [31:0]            req_segment_breakpoint,
   input  logic [31:0]            req_sample_x,
   input  logic [31:0]            req_sample_y,
   input  logic                   req_last_sample,
   input  logic                   pop,
   output logic                   head_valid,
   output pll_pkg::item_type      head,
   output logic [pll_pkg::Q_CNT_W-1:0] q_count
);
   import pll_pkg::*;

   item_type             mem [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 keep, push, do_pop;
   item_type             entry;

   // writes to a segment outside the table are dropped here
   always_comb begin
      keep = (op_type'(req_operation) == OP_SAMPLE) ||
             ((req_segment_index != 4'd0) && (32'(req_segment_index) <= MAX_SEGMENTS));
      entry.is_write = (op_type'(req_operation) == OP_WRITE);
      entry.seg      = SEG_IDX_W'(req_segment_index - 4'd1);
      entry.slope    = req_segment_slope;
      entry.bp       = req_segment_breakpoint;
      entry.x        = req_sample_x;
      entry.y        = req_sample_y;
      entry.last     = req_last_sample;
   end

   assign req_ready  = (count_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready && keep;
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;
   assign head       = mem[rd_ptr_ff];
   assign q_count    = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/pll_back.sv]
module pll_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pll_pkg::cfg_type         cfg,
   input  logic                     head_valid,
   input  pll_pkg::item_type        head,
   output logic                     pop,
   output pll_pkg::back_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_predicted_y,
   output logic [47:0]              rsp_log_likelihood,
   output logic                     rsp_is_last,
   output logic                     rsp_saturated
);
   import pll_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b0_0000_0001,
      ST_SEL  = 9'b0_0000_0010,
      ST_MUL  = 9'b0_0000_0100,
      ST_ADD  = 9'b0_0000_1000,
      ST_RES  = 9'b0_0001_0000,
      ST_SQ   = 9'b0_0010_0000,
      ST_PROD = 9'b0_0100_0000,
      ST_PEN  = 9'b0_1000_0000,
      ST_ACC  = 9'b1_0000_0000
   } state_type;

   localparam logic [63:0] PENALTY_CAP = 64'h0001_0000_0000_0000;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] slope_tab [MAX_SEGMENTS];
   logic [DATA_W-1:0] bp_tab    [MAX_SEGMENTS];

   logic [DATA_W-1:0]        x_ff, y_ff;
   logic                     last_ff;
   logic [CNT_W-1:0]         j_ff, j_in, k_ff, k_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0]        prev_ff, prev_in;
   logic signed [64:0]       prod_ff;
   logic [DATA_W-1:0]        pred_ff;
   logic [DATA_W-1:0]        mag_ff;
   logic [63:0]              sq_ff, ph_ff, pl_ff;
   logic [PEN_W-1:0]         pen_ff, pen_in;
   logic [ACC_W-1:0]         acc_ff;
   logic                     sat_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_pred_ff;
   logic [47:0]              rsp_ll_ff;
   logic                     rsp_last_ff, rsp_sat_ff;

   logic [SEG_IDX_W-1:0]     seg;
   logic signed [32:0]       len;
   logic signed [64:0]       rnd;
   logic [TERM_W-1:0]        term;
   logic                     pred_ovf;
   logic [DATA_W-1:0]        pred_val;
   logic signed [32:0]       resid;
   logic [64:0]              lo_rnd;
   logic [64:0]              pen_sum;
   logic                     pen_clamp;
   logic signed [50:0]       acc_sum;
   logic                     acc_ovf;
   logic [ACC_W-1:0]         acc_val;
   logic                     out_free, load;

   assign seg      = SEG_IDX_W'(k_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = (state_ff == ST_ACC) && out_free;
   assign pop      = (state_ff == ST_IDLE) && head_valid;

   // first breakpoint above x among the first count-1 segments
   always_comb begin
      j_in = cfg.count;
      for (int i = MAX_SEGMENTS - 1; i >= 1; i--) begin
         if ((CNT_W'(i) < cfg.count) && ($signed(x_ff) < $signed(bp_tab[i-1]))) begin
            j_in = CNT_W'(i);
         end
      end
   end

   always_comb begin
      len  = (k_ff == j_ff) ? ($signed({x_ff[31], x_ff}) - $signed({prev_ff[31], prev_ff}))
                            : ($signed({bp_tab[seg][31], bp_tab[seg]}) -
                               $signed({prev_ff[31], prev_ff}));
      rnd  = prod_ff + 65'sd32768;
      term = rnd[64:16];
      pred_ovf = (sum_ff[SUM_W-1:31] != '0) && (sum_ff[SUM_W-1:31] != '1);
      pred_val = !pred_ovf ? sum_ff[31:0] :
                 (sum_ff[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      resid    = $signed({y_ff[31], y_ff}) - $signed({pred_val[31], pred_val});
      lo_rnd   = {1'b0, pl_ff} + 65'h0_8000_0000;
      pen_sum  = {1'b0, ph_ff} + {32'd0, lo_rnd[64:32]};
      pen_clamp = (ph_ff > PENALTY_CAP) || (pen_sum > {1'b0, PENALTY_CAP});
      pen_in    = pen_clamp ? PEN_W'(PENALTY_CAP) : pen_sum[PEN_W-1:0];
      acc_sum  = $signed({{3{acc_ff[ACC_W-1]}}, acc_ff}) +
                 $signed({{19{cfg.log_norm[31]}}, cfg.log_norm}) -
                 $signed({2'b00, pen_ff});
      acc_ovf  = (acc_sum[50:47] != 4'b0000) && (acc_sum[50:47] != 4'b1111);
      acc_val  = !acc_ovf ? acc_sum[47:0] :
                 (acc_sum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && !head.is_write) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            k_in     = CNT_W'(1);
            sum_in   = SUM_W'($signed(cfg.intercept));
            prev_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: begin
            sum_in  = sum_ff + SUM_W'($signed(term));
            prev_in = bp_tab[seg];
            if (k_ff == j_ff) begin
               state_in = ST_RES;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_RES:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_PROD;
         ST_PROD: state_in = ST_PEN;
         ST_PEN:  state_in = ST_ACC;
         ST_ACC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and tables
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.is_write) begin
            slope_tab[head.seg] <= head.slope;
            bp_tab[head.seg]    <= head.bp;
         end
         x_ff    <= head.x;
         y_ff    <= head.y;
         last_ff <= head.last;
      end
      if (state_ff == ST_SEL) begin
         j_ff <= j_in;
      end
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      prev_ff <= prev_in;
      prod_ff <= $signed(slope_tab[seg]) * len;
      if (state_ff == ST_RES) begin
         pred_ff <= pred_val;
         mag_ff  <= resid[32] ? 32'(-resid) : resid[31:0];
      end
      sq_ff <= mag_ff * mag_ff;
      ph_ff <= sq_ff[63:32] * cfg.inv_two_variance;
      pl_ff <= sq_ff[31:0] * cfg.inv_two_variance;
      if (state_ff == ST_PEN) begin
         pen_ff <= pen_in;
      end
      if (load) begin
         rsp_pred_ff <= pred_ff;
         rsp_ll_ff   <= acc_val;
         rsp_last_ff <= last_ff;
         rsp_sat_ff  <= sat_ff || acc_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_RES) && pred_ovf) begin
            sat_ff <= 1'b1;
         end
         if ((state_ff == ST_PEN) && pen_clamp) begin
            sat_ff <= 1'b1;
         end
         if (load) begin
            acc_ff <= last_ff ? '0 : acc_val;
            sat_ff <= last_ff ? 1'b0 : (sat_ff || acc_ovf);
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.busy         = (state_ff != ST_IDLE);
   assign status.loading      = load;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_y     = rsp_pred_ff;
   assign rsp_log_likelihood  = rsp_ll_ff;
   assign rsp_is_last         = rsp_last_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

[rtl/piecewise_linear_loglik.sv]
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  operation, segment fields, sample fields, last
// rsp       out  rsp_valid/rsp_ready  predicted_y, log_likelihood, is_last, saturated
// csr       in   csr_write_enable     csr_index, csr_write_data
//
// a table write is applied as it leaves the queue; a sample runs the back end's MUL and ADD
// steps once per segment up to j, the chosen segment, through one shared multiplier
// a two-entry queue sits between front and back; the result sits in an output register
// reset is synchronous; tables are not cleared and need writing before use
// a stalled result holds the back end in its last step, the front keeps filling the queue
module piecewise_linear_loglik (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [3:0]  req_segment_index,
   input  logic [31:0] req_segment_slope,
   input  logic [31:0] req_segment_breakpoint,
   input  logic [31:0] req_sample_x,
   input  logic [31:0] req_sample_y,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_predicted_y,
   output logic [47:0] rsp_log_likelihood,
   output logic        rsp_is_last,
   output logic        rsp_saturated,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import pll_pkg::*;

   `include "piecewise_linear_loglik_defines.svh"

   logic [3:0]        count_raw_ff;
   logic [DATA_W-1:0] intercept_ff, itv_ff, log_norm_ff;
   cfg_type           cfg;
   logic              head_valid, pop;
   item_type          head;
   logic [Q_CNT_W-1:0] q_count;
   back_status_type   back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_raw_ff <= 4'd1;
         intercept_ff <= '0;
         itv_ff       <= ITV_RESET;
         log_norm_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEGMENT_COUNT:    count_raw_ff <= csr_write_data[3:0];
            CSR_INTERCEPT:        intercept_ff <= csr_write_data;
            CSR_INV_TWO_VARIANCE: itv_ff       <= csr_write_data;
            CSR_LOG_NORM:         log_norm_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // zero counts as one segment, anything above the table size as the full table
   always_comb begin
      if (count_raw_ff == 4'd0) begin
         cfg.count = CNT_W'(1);
      end else if (32'(count_raw_ff) > MAX_SEGMENTS) begin
         cfg.count = CNT_W'(MAX_SEGMENTS);
      end else begin
         cfg.count = CNT_W'(count_raw_ff);
      end
      cfg.intercept        = intercept_ff;
      cfg.inv_two_variance = itv_ff;
      cfg.log_norm         = log_norm_ff;
   end

   pll_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_segment_index      (req_segment_index),
      .req_segment_slope      (req_segment_slope),
      .req_segment_breakpoint (req_segment_breakpoint),
      .req_sample_x           (req_sample_x),
      .req_sample_y           (req_sample_y),
      .req_last_sample        (req_last_sample),
      .pop                    (pop),
      .head_valid             (head_valid),
      .head                   (head),
      .q_count                (q_count)
   );

   pll_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head_valid         (head_valid),
      .head               (head),
      .pop                (pop),
      .status             (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_predicted_y    (rsp_predicted_y),
      .rsp_log_likelihood (rsp_log_likelihood),
      .rsp_is_last        (rsp_is_last),
      .rsp_saturated      (rsp_saturated)
   );

   `PLL_ASSERT_IMPL(a_ready_only_when_room, !req_ready, q_count == Q_CNT_W'(QUEUE_DEPTH))
   `PLL_ASSERT_NEXT(a_load_shows_result, back_status.loading, rsp_valid)
   `PLL_ASSERT_IMPL(a_result_from_back, $rose(rsp_valid), $past(back_status.busy))

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import pll_pkg::*;

   localparam int  CYCLE_LIMIT = 1_000_000;
   localparam int  SETTLE      = 30;
   localparam int  PHASES      = 10;
   localparam int  PHASE_ITEMS = 190;
   localparam logic [63:0] PENALTY_CAP = 64'd1 << 48;
   localparam longint LL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint LL_MIN = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic        op;
      logic [3:0]  idx;
      logic [31:0] slope;
      logic [31:0] bp;
      logic [31:0] x;
      logic [31:0] y;
      logic        last;
   } req_item_t;

   typedef struct packed {
      logic [31:0] pred;
      logic [47:0] ll;
      logic        last;
      logic        sat;
   } loglik_t;

   typedef struct packed {
      req_item_t   item;
      logic        known;
      logic [31:0] pred;
      logic [47:0] ll;
      logic        sat;
   } stim_row_t;

   localparam int NROWS = 20;
   localparam stim_row_t DIRECTED[NROWS] = '{
      '{'{OP_WRITE, 4'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd2, 32'h0, 32'h0002_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd3, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd4, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd5, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd6, 32'h0, 32'h0006_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd7, 32'h0, 32'h0007_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd8, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      // bad indexes are dropped
      '{'{OP_WRITE, 4'd0, 32'h7, 32'h0, 32'h0, 32'h0, 1'b1}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd9, 32'h7, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_SAMPLE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, 32'h0, 48'h0, 1'b0},
      '{'{OP_SAMPLE, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1},
        1'b1, 32'h0, 48'hFFFF_FFFF_8000, 1'b0},
      '{'{OP_SAMPLE, 4'd0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0}, 1'b1, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'h0, 1'b0},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_SAMPLE, 4'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd1, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_SAMPLE, 4'd0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_WRITE, 4'd1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0},
        1'b0, 32'h0, 48'h0, 1'b0},
      '{'{OP_SAMPLE, 4'd0, 32'h0, 32'h0, 32'h0003_0000, 32'h0003_0000, 1'b1},
        1'b1, 32'h0003_0000, 48'h0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [3:0]  req_segment_index = '0;
   logic [31:0] req_segment_slope = '0;
   logic [31:0] req_segment_breakpoint = '0;
   logic [31:0] req_sample_x = '0;
   logic [31:0] req_sample_y = '0;
   logic        req_last_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_predicted_y;
   logic [47:0] rsp_log_likelihood;
   logic        rsp_is_last;
   logic        rsp_saturated;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   // model state
   int          seg_count;
   longint      intercept_q;
   logic [31:0] inv_two_var;
   longint      log_norm_q;
   longint      slope_tbl[MAX_SEGMENTS];
   longint      bp_tbl[MAX_SEGMENTS];
   longint      loglik_acc;
   logic        sat_seen;

   loglik_t     pending_results[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;

   always #2 clock = ~clock;

   piecewise_linear_loglik DUT (.*);

   function automatic longint seg_term(longint s, longint len);
      return (s * len + 32768) >>> 16;
   endfunction

   function automatic loglik_t predict_sample(logic [31:0] xv, logic [31:0] yv, logic lastv);
      loglik_t     res;
      longint      x, y, sum, prev_bp, pred, r;
      logic [63:0] mag, sq, hi, lo, pen;
      int          n, j;
      x = $signed(xv);
      y = $signed(yv);
      n = seg_count;
      if (n < 1) n = 1;
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      j = 1;
      while (j < n && x >= bp_tbl[j-1]) j++;
      sum = intercept_q;
      prev_bp = 0;
      for (int k = 1; k < j; k++) begin
         sum += seg_term(slope_tbl[k-1], bp_tbl[k-1] - prev_bp);
         prev_bp = bp_tbl[k-1];
      end
      sum += seg_term(slope_tbl[j-1], x - prev_bp);
      pred = sum;
      if (pred > 64'sd2147483647) begin
         pred = 64'sd2147483647;
         sat_seen = 1'b1;
      end
      if (pred < -64'sd2147483648) begin
         pred = -64'sd2147483648;
         sat_seen = 1'b1;
      end
      r = y - pred;
      mag = (r < 0) ? -r : r;
      sq = mag * mag;
      hi = sq >> 32;
      lo = {32'd0, sq[31:0]};
      pen = hi * {32'd0, inv_two_var};
      if (pen > PENALTY_CAP) begin
         pen = PENALTY_CAP;
         sat_seen = 1'b1;
      end else begin
         pen += (lo * {32'd0, inv_two_var} + 64'h8000_0000) >> 32;
         if (pen > PENALTY_CAP) begin
            pen = PENALTY_CAP;
            sat_seen = 1'b1;
         end
      end
      sum = loglik_acc + log_norm_q - longint'(pen);
      if (sum > LL_MAX) begin
         sum = LL_MAX;
         sat_seen = 1'b1;
      end
      if (sum < LL_MIN) begin
         sum = LL_MIN;
         sat_seen = 1'b1;
      end
      loglik_acc = sum;
      res.pred = pred[31:0];
      res.ll   = sum[47:0];
      res.last = lastv;
      res.sat  = sat_seen;
      if (lastv) begin
         loglik_acc = 0;
         sat_seen = 1'b0;
      end
      return res;
   endfunction

   // called at the edge where the item is accepted
   function automatic void apply_item(stim_row_t row);
      loglik_t res;
      if (row.item.op == OP_WRITE) begin
         if (row.item.idx >= 1 && row.item.idx <= MAX_SEGMENTS) begin
            slope_tbl[row.item.idx-1] = $signed(row.item.slope);
            bp_tbl[row.item.idx-1]    = $signed(row.item.bp);
         end
      end else begin
         res = predict_sample(row.item.x, row.item.y, row.item.last);
         if (row.known) begin
            res.pred = row.pred;
            res.ll   = row.ll;
            res.sat  = row.sat;
         end
         pending_results.push_back(res);
      end
   endfunction

   task automatic send_item(stim_row_t row);
      req_operation          <= row.item.op;
      req_segment_index      <= row.item.idx;
      req_segment_slope      <= row.item.slope;
      req_segment_breakpoint <= row.item.bp;
      req_sample_x           <= row.item.x;
      req_sample_y           <= row.item.y;
      req_last_sample        <= row.item.last;
      req_valid              <= 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_item(row);
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type i, logic [31:0] d);
      csr_write_enable <= 1'b1;
      csr_index        <= i;
      csr_write_data   <= d;
      @(posedge clock);
      case (i)
         CSR_SEGMENT_COUNT:    seg_count   = int'(d[3:0]);
         CSR_INTERCEPT:        intercept_q = $signed(d);
         CSR_INV_TWO_VARIANCE: inv_two_var = d;
         CSR_LOG_NORM:         log_norm_q  = $signed(d);
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic stim_row_t random_sample(logic lastv);
      stim_row_t row;
      row = '0;
      row.item.op   = OP_SAMPLE;
      row.item.idx  = 4'($urandom);
      row.item.slope = $urandom;
      row.item.bp   = $urandom;
      row.item.x    = ($urandom_range(0, 3) == 0) ? pick_value()
                                                  : $urandom_range(0, 32'h000A_0000) - 32'h0001_0000;
      row.item.y    = pick_value();
      row.item.last = lastv;
      return row;
   endfunction

   // ascending breakpoints so every segment is reachable
   task automatic load_sorted_table();
      stim_row_t   row;
      logic [31:0] bp;
      bp = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      for (int k = 1; k <= MAX_SEGMENTS; k++) begin
         row = '0;
         row.item.op    = OP_WRITE;
         row.item.idx   = 4'(k);
         row.item.slope = pick_value();
         row.item.bp    = bp;
         row.item.x     = $urandom;
         row.item.y     = $urandom;
         row.item.last  = 1'($urandom);
         send_item(row);
         bp += $urandom_range(1, 32'h0002_0000);
      end
   endtask

   initial begin
      stim_row_t row;
      int        left, set_len;
      seg_count   = 1;
      intercept_q = 0;
      inv_two_var = ITV_RESET;
      log_norm_q  = 0;
      loglik_acc  = 0;
      sat_seen    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NROWS; i++) send_item(DIRECTED[i]);
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_csr(CSR_SEGMENT_COUNT, 32'd0);
               write_csr(CSR_INTERCEPT, 32'h7FFF_FFFF);
               write_csr(CSR_INV_TWO_VARIANCE, 32'hFFFF_FFFF);
               write_csr(CSR_LOG_NORM, 32'h8000_0000);
            end
            1: begin
               write_csr(CSR_SEGMENT_COUNT, 32'd15);
               write_csr(CSR_INTERCEPT, 32'h8000_0000);
               write_csr(CSR_INV_TWO_VARIANCE, 32'd0);
               write_csr(CSR_LOG_NORM, 32'h7FFF_FFFF);
            end
            2: begin
               write_csr(CSR_SEGMENT_COUNT, 32'd8);
               write_csr(CSR_INTERCEPT, 32'd0);
               write_csr(CSR_INV_TWO_VARIANCE, 32'd1);
               write_csr(CSR_LOG_NORM, 32'd0);
            end
            default: begin
               write_csr(CSR_SEGMENT_COUNT, $urandom_range(0, 15));
               write_csr(CSR_INTERCEPT, pick_value());
               write_csr(CSR_INV_TWO_VARIANCE, ($urandom_range(0, 4) == 0) ? $urandom
                                                : $urandom_range(0, 32'h0002_0000));
               write_csr(CSR_LOG_NORM, pick_value());
            end
         endcase
         csr_write_enable <= 1'b0;
         if ($urandom_range(0, 2) != 0) load_sorted_table();
         left = PHASE_ITEMS;
         while (left > 0) begin
            set_len = $urandom_range(1, 20);
            for (int s = 0; s < set_len && left > 0; s++) begin
               if ($urandom_range(0, 9) == 0) begin
                  row = '0;
                  row.item.op    = OP_WRITE;
                  row.item.idx   = 4'($urandom);
                  row.item.slope = pick_value();
                  row.item.bp    = pick_value();
                  row.item.x     = $urandom;
                  row.item.y     = $urandom;
                  row.item.last  = 1'($urandom);
               end else begin
                  row = random_sample(s == set_len - 1 || left == 1);
               end
               send_item(row);
               left--;
            end
         end
      end
      wait_idle();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: checks each result item and stalls in changing patterns
   always @(posedge clock) begin
      loglik_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result item pred %h ll %h", $time,
                     rsp_predicted_y, rsp_log_likelihood);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_predicted_y !== want.pred) begin
               $display("%0t predicted_y expected %h actual %h", $time,
                        want.pred, rsp_predicted_y);
               mismatches++;
            end
            if (rsp_log_likelihood !== want.ll) begin
               $display("%0t log_likelihood expected %h actual %h", $time,
                        want.ll, rsp_log_likelihood);
               mismatches++;
            end
            if (rsp_is_last !== want.last) begin
               $display("%0t is_last expected %b actual %b", $time, want.last, rsp_is_last);
               mismatches++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t saturated expected %b actual %b", $time, want.sat, rsp_saturated);
               mismatches++;
            end
         end
      end
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

endmodule
